>>> hdl/bounded_double_ended_queue_top_macros.svh
// Assertion helpers used by the queue core.
// Each macro expects clk and rst_n to be visible where it is used.
`ifndef BOUNDED_DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH
`define BOUNDED_DOUBLE_ENDED_QUEUE_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define BDQ_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define BDQ_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

>>> hdl/bdq_pkg.sv
package bdq_pkg;

    // Built storage depth of the entry ring.
    localparam int DEPTH   = 16;
    localparam int ADDR_W  = $clog2(DEPTH);
    localparam int CNT_W   = $clog2(DEPTH + 1);
    localparam int SUM_W   = CNT_W + 1;

    localparam int WORD_W  = 32;
    localparam int CAP_W   = 5;
    localparam int CNT_OUT_W = 5;
    localparam int OP_W    = 3;
    localparam int STAT_W  = 2;

    // Configuration port geometry: one 32-bit register at byte address 0.
    localparam int PDATA_W = 32;
    localparam int PADDR_W = 3;
    localparam int REG_IDX_LSB = 2;
    localparam int REG_IDX_W = PADDR_W - REG_IDX_LSB;
    localparam logic [REG_IDX_W-1:0] REG_CAPACITY = '0;

    localparam logic [CAP_W-1:0] CAPACITY_RESET = CAP_W'(16);
    localparam logic signed [WORD_W-1:0] WORD_EMPTY = -32'sd1;

    typedef enum logic [OP_W-1:0] {
        OP_INS_FRONT = 3'd0,
        OP_INS_REAR  = 3'd1,
        OP_DEL_FRONT = 3'd2,
        OP_DEL_REAR  = 3'd3,
        OP_PEEK      = 3'd4
    } opcode_t;

    typedef enum logic [STAT_W-1:0] {
        ST_DONE  = 2'd0,
        ST_FULL  = 2'd1,
        ST_EMPTY = 2'd2
    } status_t;

    typedef struct packed {
        status_t                   status;
        logic signed [WORD_W-1:0]  front;
        logic signed [WORD_W-1:0]  rear;
        logic [CNT_W-1:0]          count;
        logic                      empty;
    } result_t;

endpackage

>>> hdl/bounded_double_ended_queue_top.sv
// Channel   | Handshake           | Payload
// ----------+---------------------+---------------------------------------------
// input     | in_valid / in_stall | opcode, value
// output    | out_valid/out_stall | status, front_value, rear_value, count,
//           |                     | empty_flag
// config    | APB psel/penable    | paddr, pwdata, prdata (capacity at 0x0)
//
// An insert, a peek, a rejected operation or a delete that empties the queue
// is answered in the cycle after it is taken. A delete that leaves words first
// reads the new front or rear word from the entry RAM, in state S_READ.
// Reset (rst_n, asynchronous) empties the queue and sets capacity to 16;
// the entry RAM is not cleared. Results sit in an output register, and a
// new item is taken in the same cycle that the waiting result is taken.
module bounded_double_ended_queue_top (
    input  logic                                clk,
    input  logic                                rst_n,

    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [bdq_pkg::PADDR_W-1:0]         paddr,
    input  logic [bdq_pkg::PDATA_W-1:0]         pwdata,
    output logic [bdq_pkg::PDATA_W-1:0]         prdata,
    output logic                                pready,

    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [bdq_pkg::OP_W-1:0]            opcode,
    input  logic signed [bdq_pkg::WORD_W-1:0]   value,

    output logic                                out_valid,
    input  logic                                out_stall,
    output logic [bdq_pkg::STAT_W-1:0]          status,
    output logic signed [bdq_pkg::WORD_W-1:0]   front_value,
    output logic signed [bdq_pkg::WORD_W-1:0]   rear_value,
    output logic [bdq_pkg::CNT_OUT_W-1:0]       count,
    output logic                                empty_flag
);

    // Capacity register; values above the built depth act as the depth.
    logic [bdq_pkg::CAP_W-1:0] capacity;
    bdq_pkg::result_t          result;

    bdq_cfg u_cfg (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .capacity (capacity)
    );

    // The core keeps the head slot and word count in registers, the words in
    // a ring held in RAM, and copies of the current front and rear words so
    // that only a delete needs a RAM read.
    bdq_core u_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .capacity  (capacity),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .opcode    (opcode),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .result    (result)
    );

    // The result register fans out to the individual payload ports.
    assign status      = result.status;
    assign front_value = result.front;
    assign rear_value  = result.rear;
    assign count       = bdq_pkg::CNT_OUT_W'(result.count);
    assign empty_flag  = result.empty;

endmodule

>>> hdl/bdq_ram.sv
module bdq_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

>>> hdl/bdq_cfg.sv
module bdq_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            psel,
    input  logic                            penable,
    input  logic                            pwrite,
    input  logic [bdq_pkg::PADDR_W-1:0]     paddr,
    input  logic [bdq_pkg::PDATA_W-1:0]     pwdata,
    output logic [bdq_pkg::PDATA_W-1:0]     prdata,
    output logic                            pready,
    output logic [bdq_pkg::CAP_W-1:0]       capacity
);

    logic [bdq_pkg::CAP_W-1:0]     capacity_reg;
    logic [bdq_pkg::CAP_W-1:0]     capacity_next;
    logic [bdq_pkg::REG_IDX_W-1:0] reg_idx;
    logic                          wr_hit;

    assign reg_idx = paddr[bdq_pkg::PADDR_W-1:bdq_pkg::REG_IDX_LSB];
    assign pready  = 1'b1;
    assign wr_hit  = psel && penable && pwrite && pready && (reg_idx == bdq_pkg::REG_CAPACITY);

    always_comb
    begin
        capacity_next = capacity_reg;
        if (wr_hit)
        begin
            capacity_next = pwdata[bdq_pkg::CAP_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            capacity_reg <= bdq_pkg::CAPACITY_RESET;
        end
        else
        begin
            capacity_reg <= capacity_next;
        end
    end

    // Unmapped addresses read as zero.
    assign prdata   = (reg_idx == bdq_pkg::REG_CAPACITY) ?
                      bdq_pkg::PDATA_W'(capacity_reg) : '0;
    assign capacity = capacity_reg;

endmodule

>>> hdl/bdq_core.sv
`include "bounded_double_ended_queue_top_macros.svh"

module bdq_core (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic [bdq_pkg::CAP_W-1:0]           capacity,
    input  logic                                in_valid,
    output logic                                in_stall,
    input  logic [bdq_pkg::OP_W-1:0]            opcode,
    input  logic signed [bdq_pkg::WORD_W-1:0]   value,
    output logic                                out_valid,
    input  logic                                out_stall,
    output bdq_pkg::result_t                    result
);

    typedef enum logic {
        S_IDLE,
        S_READ
    } state_t;

    state_t                          state_reg, state_next;
    logic [bdq_pkg::ADDR_W-1:0]      head_reg, head_next;
    logic [bdq_pkg::CNT_W-1:0]       cnt_reg, cnt_next;
    logic signed [bdq_pkg::WORD_W-1:0] front_reg, front_next;
    logic signed [bdq_pkg::WORD_W-1:0] rear_reg, rear_next;
    logic                            rd_front_reg, rd_front_next;
    logic                            out_valid_reg, out_valid_next;
    bdq_pkg::result_t                res_reg, res_next;

    logic                            accept;
    logic                            out_free;
    logic [bdq_pkg::CNT_W-1:0]       usable;
    logic                            full;
    bdq_pkg::status_t                status;
    logic                            need_read;

    logic                            mem_we;
    logic [bdq_pkg::ADDR_W-1:0]      mem_waddr;
    logic                            mem_re;
    logic [bdq_pkg::ADDR_W-1:0]      mem_raddr;
    logic [bdq_pkg::WORD_W-1:0]      mem_rdata;

    // Ring slot at a given offset from a base slot; offset never exceeds DEPTH.
    function automatic logic [bdq_pkg::ADDR_W-1:0] slot_add(
        input logic [bdq_pkg::ADDR_W-1:0] base,
        input logic [bdq_pkg::CNT_W-1:0]  offset
    );
        logic [bdq_pkg::SUM_W-1:0] sum;
        sum = bdq_pkg::SUM_W'(base) + bdq_pkg::SUM_W'(offset);
        if (sum >= bdq_pkg::SUM_W'(bdq_pkg::DEPTH))
        begin
            sum = sum - bdq_pkg::SUM_W'(bdq_pkg::DEPTH);
        end
        return sum[bdq_pkg::ADDR_W-1:0];
    endfunction

    function automatic logic [bdq_pkg::ADDR_W-1:0] slot_dec(
        input logic [bdq_pkg::ADDR_W-1:0] base
    );
        logic [bdq_pkg::ADDR_W-1:0] res;
        if (base == '0)
        begin
            res = bdq_pkg::ADDR_W'(bdq_pkg::DEPTH - 1);
        end
        else
        begin
            res = base - 1'b1;
        end
        return res;
    endfunction

    assign out_free = !out_valid_reg || !out_stall;
    assign in_stall = (state_reg != S_IDLE) || !out_free;
    assign accept   = in_valid && !in_stall;

    always_comb
    begin
        if (32'(capacity) > 32'(bdq_pkg::DEPTH))
        begin
            usable = bdq_pkg::CNT_W'(bdq_pkg::DEPTH);
        end
        else
        begin
            usable = bdq_pkg::CNT_W'(capacity);
        end
    end

    assign full = cnt_reg >= usable;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        cnt_next       = cnt_reg;
        front_next     = front_reg;
        rear_next      = rear_reg;
        rd_front_next  = rd_front_reg;
        out_valid_next = out_valid_reg && out_stall;
        res_next       = res_reg;
        status         = bdq_pkg::ST_DONE;
        need_read      = 1'b0;
        mem_we         = 1'b0;
        mem_waddr      = head_reg;
        mem_re         = 1'b0;
        mem_raddr      = head_reg;

        if (state_reg == S_READ)
        begin
            // The new end word arrives from the memory this cycle.
            if (rd_front_reg)
            begin
                front_next = mem_rdata;
            end
            else
            begin
                rear_next = mem_rdata;
            end
            res_next.status = bdq_pkg::ST_DONE;
            res_next.front  = front_next;
            res_next.rear   = rear_next;
            res_next.count  = cnt_reg;
            res_next.empty  = 1'b0;
            out_valid_next  = 1'b1;
            state_next      = S_IDLE;
        end
        else if (accept)
        begin
            case (opcode)
                bdq_pkg::OP_INS_FRONT,
                bdq_pkg::OP_INS_REAR:
                begin
                    if (full)
                    begin
                        status = bdq_pkg::ST_FULL;
                    end
                    else
                    begin
                        mem_we = 1'b1;
                        if (opcode == bdq_pkg::OP_INS_FRONT)
                        begin
                            head_next  = slot_dec(head_reg);
                            mem_waddr  = head_next;
                            front_next = value;
                            if (cnt_reg == '0)
                            begin
                                rear_next = value;
                            end
                        end
                        else
                        begin
                            mem_waddr = slot_add(head_reg, cnt_reg);
                            rear_next = value;
                            if (cnt_reg == '0)
                            begin
                                front_next = value;
                            end
                        end
                        cnt_next = cnt_reg + 1'b1;
                    end
                end
                bdq_pkg::OP_DEL_FRONT,
                bdq_pkg::OP_DEL_REAR:
                begin
                    if (cnt_reg == '0)
                    begin
                        status = bdq_pkg::ST_EMPTY;
                    end
                    else
                    begin
                        cnt_next = cnt_reg - 1'b1;
                        if (opcode == bdq_pkg::OP_DEL_FRONT)
                        begin
                            head_next = slot_add(head_reg, bdq_pkg::CNT_W'(1));
                            mem_raddr = head_next;
                        end
                        else
                        begin
                            mem_raddr = slot_add(head_reg, cnt_next - 1'b1);
                        end
                        // A delete that leaves words must fetch the new end word.
                        if (cnt_next != '0)
                        begin
                            need_read     = 1'b1;
                            mem_re        = 1'b1;
                            rd_front_next = (opcode == bdq_pkg::OP_DEL_FRONT);
                            state_next    = S_READ;
                        end
                    end
                end
                default:
                begin
                    status = bdq_pkg::ST_DONE;
                end
            endcase

            if (!need_read)
            begin
                res_next.status = status;
                res_next.front  = (cnt_next == '0) ? bdq_pkg::WORD_EMPTY : front_next;
                res_next.rear   = (cnt_next == '0) ? bdq_pkg::WORD_EMPTY : rear_next;
                res_next.count  = cnt_next;
                res_next.empty  = (cnt_next == '0);
                out_valid_next  = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            cnt_reg       <= '0;
            front_reg     <= '0;
            rear_reg      <= '0;
            rd_front_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            res_reg       <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            cnt_reg       <= cnt_next;
            front_reg     <= front_next;
            rear_reg      <= rear_next;
            rd_front_reg  <= rd_front_next;
            out_valid_reg <= out_valid_next;
            res_reg       <= res_next;
        end
    end

    bdq_ram #(
        .WIDTH (bdq_pkg::WORD_W),
        .DEPTH (bdq_pkg::DEPTH)
    ) u_entry_ram (
        .clk   (clk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (value),
        .re    (mem_re),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    assign out_valid = out_valid_reg;
    assign result    = res_reg;

    `BDQ_ASSERT_NOW(a_cnt_in_range, 1'b1, cnt_reg <= bdq_pkg::CNT_W'(bdq_pkg::DEPTH),
        "word count exceeds storage depth")
    `BDQ_ASSERT_NOW(a_read_has_words, state_reg == S_READ, cnt_reg != '0,
        "end-word fetch pending on an empty queue")
    `BDQ_ASSERT_NOW(a_empty_matches, out_valid_reg, res_reg.empty == (res_reg.count == '0),
        "empty flag disagrees with count")
    `BDQ_ASSERT_NOW(a_result_source, $rose(out_valid_reg),
        $past(accept) || $past(state_reg == S_READ),
        "result appeared without an item")

endmodule

>>> tb/bdq_tb_pkg.sv
package bdq_tb_pkg;

    import bdq_pkg::*;

    // Shadow copy of the deque. It predicts one result per accepted item and
    // checks the results that the block returns, oldest first.
    class deque_mirror;

        logic [WORD_W-1:0] words [DEPTH];
        logic [ADDR_W-1:0] head;
        logic [CNT_W-1:0]  held;
        logic [CAP_W-1:0]  capacity;

        result_t     awaited_results [$];
        int unsigned mismatches;
        int unsigned results_seen;

        localparam int unsigned PRINT_LIMIT = 60;

        function new();
            foreach (words[i])
                words[i] = '0;
            head = '0;
            held = '0;
            capacity = CAPACITY_RESET;
            mismatches = 0;
            results_seen = 0;
        endfunction

        function void set_capacity(logic [CAP_W-1:0] cap);
            capacity = cap;
        endfunction

        function int unsigned pending();
            return awaited_results.size();
        endfunction

        task report(string msg);
            mismatches++;
            if (mismatches <= PRINT_LIMIT)
                $display("MISMATCH: %s", msg);
        endtask

        // Applies one operation to the shadow ring and queues its result.
        function void note_item(logic [OP_W-1:0] op, logic [WORD_W-1:0] word);
            result_t           outcome;
            logic [CNT_W-1:0]  usable;
            logic [ADDR_W-1:0] slot;
            logic              at_limit;

            outcome.status = ST_DONE;
            usable = (capacity > DEPTH) ? CNT_W'(DEPTH) : capacity;
            at_limit = (held >= usable);

            case (op)
                OP_INS_FRONT, OP_INS_REAR:
                begin
                    if (at_limit)
                    begin
                        outcome.status = ST_FULL;
                    end
                    else
                    begin
                        if (op == OP_INS_FRONT)
                        begin
                            head = head - 1'b1;
                            words[head] = word;
                        end
                        else
                        begin
                            slot = head + ADDR_W'(held);
                            words[slot] = word;
                        end
                        held = held + 1'b1;
                    end
                end
                OP_DEL_FRONT, OP_DEL_REAR:
                begin
                    if (held == 0)
                    begin
                        outcome.status = ST_EMPTY;
                    end
                    else
                    begin
                        if (op == OP_DEL_FRONT)
                            head = head + 1'b1;
                        held = held - 1'b1;
                    end
                end
                default:
                begin
                end
            endcase

            if (held != 0)
            begin
                slot = head + ADDR_W'(held - 1'b1);
                outcome.front = words[head];
                outcome.rear = words[slot];
            end
            else
            begin
                outcome.front = WORD_EMPTY;
                outcome.rear = WORD_EMPTY;
            end
            outcome.count = held;
            outcome.empty = (held == 0);
            awaited_results.push_back(outcome);
        endfunction

        task check_item(logic [STAT_W-1:0] got_status, logic [WORD_W-1:0] got_front,
                        logic [WORD_W-1:0] got_rear, logic [CNT_OUT_W-1:0] got_count,
                        logic got_empty);
            result_t want;

            results_seen++;
            if (awaited_results.size() == 0)
            begin
                report($sformatf("result %0d arrived with nothing expected", results_seen));
                return;
            end
            want = awaited_results.pop_front();
            if (got_status !== want.status)
                report($sformatf("result %0d status got %0d want %0d",
                                 results_seen, got_status, want.status));
            if (got_front !== want.front)
                report($sformatf("result %0d front got %h want %h",
                                 results_seen, got_front, want.front));
            if (got_rear !== want.rear)
                report($sformatf("result %0d rear got %h want %h",
                                 results_seen, got_rear, want.rear));
            if (got_count !== want.count)
                report($sformatf("result %0d count got %0d want %0d",
                                 results_seen, got_count, want.count));
            if (got_empty !== want.empty)
                report($sformatf("result %0d empty flag got %b want %b",
                                 results_seen, got_empty, want.empty));
        endtask

    endclass

endpackage

>>> tb/bounded_double_ended_queue_top_tb.sv
module bounded_double_ended_queue_top_tb;

    import bdq_pkg::*;
    import bdq_tb_pkg::*;

    // Byte address of the capacity register on the configuration port.
    localparam logic [PADDR_W-1:0] CAPACITY_ADDR = PADDR_W'(REG_CAPACITY) << REG_IDX_LSB;

    // Opcodes above peek are unused and must behave like a peek.
    localparam logic [OP_W-1:0] OP_UNUSED_LO  = 3'd5;
    localparam logic [OP_W-1:0] OP_UNUSED_MID = 3'd6;
    localparam logic [OP_W-1:0] OP_UNUSED_HI  = 3'd7;

    // Traffic mixes for the random bursts.
    localparam int MIX_FILL  = 0;
    localparam int MIX_DRAIN = 1;
    localparam int MIX_EVEN  = 2;

    localparam int PHASES          = 12;
    localparam int ITEMS_PER_PHASE = 160;
    localparam int BURST_LEN       = 16;
    localparam int SETTLE_CYCLES   = 3;
    localparam int CYCLE_LIMIT     = 400000;

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    logic                       psel = 1'b0;
    logic                       penable = 1'b0;
    logic                       pwrite = 1'b0;
    logic [PADDR_W-1:0]         paddr = '0;
    logic [PDATA_W-1:0]         pwdata = '0;
    logic [PDATA_W-1:0]         prdata;
    logic                       pready;

    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic [OP_W-1:0]            opcode = '0;
    logic signed [WORD_W-1:0]   value = '0;

    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic [STAT_W-1:0]          status;
    logic signed [WORD_W-1:0]   front_value;
    logic signed [WORD_W-1:0]   rear_value;
    logic [CNT_OUT_W-1:0]       count;
    logic                       empty_flag;

    // Chance in percent that the sender holds back an item, and that the
    // receiver stalls in any given cycle.
    int unsigned send_idle_pct = 32;
    int unsigned stall_pct = 71;

    int unsigned cycle_count = 0;

    deque_mirror mirror;

    // Capacities visited by the random phases. They include zero, one, the
    // full storage depth and values above it, and the order makes the
    // capacity drop below the stored count more than once.
    logic [CAP_W-1:0] capacity_plan [PHASES] = '{
        5'd16, 5'd31, 5'd4, 5'd1, 5'd16, 5'd0,
        5'd17, 5'd2, 5'd8, 5'd31, 5'd16, 5'd5
    };

    bounded_double_ended_queue_top DUT (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // The receiver stalls at random, at the rate of the current phase.
    always @(posedge clk)
    begin
        out_stall <= ($urandom_range(0, 99) < stall_pct);
    end

    // Every result taken from the block is checked against the oldest
    // prediction.
    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall)
            mirror.check_item(status, front_value, rear_value, count, empty_flag);
    end

    // A hung handshake ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("FAIL bounded_double_ended_queue_top");
            $finish;
        end
    end

    // Presents one item, with a random gap in front of it, and returns at the
    // edge where the block takes it. Valid stays high on return so that
    // back-to-back items see no bubble; a gap in the next call or a drain lowers it.
    task automatic send_item(input logic [OP_W-1:0] op, input logic [WORD_W-1:0] word);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        opcode <= op;
        value <= word;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        mirror.note_item(op, word);
    endtask

    // Stops sending and waits until every predicted result has come back.
    // Every item yields a result, so a short settle is all that is needed
    // before the block counts as idle.
    task automatic wait_drained();
        in_valid <= 1'b0;
        while (mirror.pending() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES)
            @(posedge clk);
    endtask

    // Writes the capacity register, then reads it back. The upper data bits
    // are random since only the low five bits are kept. The read's setup
    // phase starts in the same cycle the write finishes, so each control
    // signal gets a single assignment per edge.
    task automatic write_capacity(input logic [CAP_W-1:0] cap);
        logic [PDATA_W-1:0] word;

        word = $urandom;
        word[CAP_W-1:0] = cap;
        psel <= 1'b1;
        penable <= 1'b0;
        pwrite <= 1'b1;
        paddr <= CAPACITY_ADDR;
        pwdata <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        mirror.set_capacity(cap);

        penable <= 1'b0;
        pwrite <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata[CAP_W-1:0] !== cap)
            mirror.report($sformatf("capacity read back %0d, written %0d",
                                    prdata[CAP_W-1:0], cap));
        psel <= 1'b0;
        penable <= 1'b0;
    endtask

    // Words are mostly random, with the signed extremes, zero and all ones
    // mixed in so that they also show up as front and rear values.
    function automatic logic [WORD_W-1:0] pick_word();
        case ($urandom_range(0, 9))
            0: return 32'h7FFF_FFFF;
            1: return 32'h8000_0000;
            2: return 32'hFFFF_FFFF;
            3: return 32'h0000_0000;
            default: return $urandom;
        endcase
    endfunction

    // Picks an opcode for the given mix. Filling mixes push the deque to its
    // capacity, draining mixes empty it, so both rejections happen often.
    function automatic logic [OP_W-1:0] pick_opcode(input int mix);
        int unsigned roll;
        int unsigned ins_pct;
        int unsigned del_pct;

        roll = $urandom_range(0, 99);
        case (mix)
            MIX_FILL:
            begin
                ins_pct = 70;
                del_pct = 20;
            end
            MIX_DRAIN:
            begin
                ins_pct = 20;
                del_pct = 70;
            end
            default:
            begin
                ins_pct = 45;
                del_pct = 45;
            end
        endcase
        if (roll < ins_pct / 2)
            return OP_INS_FRONT;
        if (roll < ins_pct)
            return OP_INS_REAR;
        if (roll < ins_pct + del_pct / 2)
            return OP_DEL_FRONT;
        if (roll < ins_pct + del_pct)
            return OP_DEL_REAR;
        if ($urandom_range(0, 1) == 1)
            return OP_PEEK;
        return OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI));
    endfunction

    initial
    begin
        int mix;

        mirror = new();
        repeat (5)
            @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed part. Start on an empty deque: a peek and both deletes,
        // which must report empty with all-ones words.
        send_item(OP_PEEK, $urandom);
        send_item(OP_DEL_FRONT, $urandom);
        send_item(OP_DEL_REAR, $urandom);

        // Extreme words at both ends, then a peek and the unused opcodes.
        send_item(OP_INS_FRONT, 32'h7FFF_FFFF);
        send_item(OP_INS_REAR, 32'h8000_0000);
        send_item(OP_INS_FRONT, 32'hFFFF_FFFF);
        send_item(OP_INS_REAR, 32'h0000_0000);
        send_item(OP_PEEK, $urandom);
        send_item(OP_UNUSED_LO, $urandom);
        send_item(OP_UNUSED_MID, $urandom);
        send_item(OP_UNUSED_HI, $urandom);

        // Delete down to empty from alternating ends, then once more.
        send_item(OP_DEL_FRONT, $urandom);
        send_item(OP_DEL_REAR, $urandom);
        send_item(OP_DEL_FRONT, $urandom);
        send_item(OP_DEL_REAR, $urandom);
        send_item(OP_DEL_FRONT, $urandom);

        // A capacity of one: the second insert is rejected as full.
        wait_drained();
        write_capacity(5'd1);
        send_item(OP_INS_REAR, $urandom);
        send_item(OP_INS_FRONT, $urandom);
        send_item(OP_DEL_FRONT, $urandom);
        send_item(OP_DEL_REAR, $urandom);

        // A capacity of zero rejects every insert.
        wait_drained();
        write_capacity(5'd0);
        send_item(OP_INS_FRONT, $urandom);
        send_item(OP_INS_REAR, $urandom);
        send_item(OP_PEEK, $urandom);

        // Random part. Each phase starts from an idle block with a new
        // capacity; the words left over from the previous phase stay, which
        // is how the capacity comes to sit below the stored count. The idle
        // rates change every four phases, ending with full-rate traffic.
        mix = MIX_EVEN;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            wait_drained();
            if (phase == PHASES / 3)
            begin
                send_idle_pct = 71;
                stall_pct = 32;
            end
            else if (phase == 2 * PHASES / 3)
            begin
                send_idle_pct = 0;
                stall_pct = 0;
            end
            write_capacity(capacity_plan[phase]);
            for (int n = 0; n < ITEMS_PER_PHASE; n++)
            begin
                if (n % BURST_LEN == 0)
                    mix = $urandom_range(MIX_FILL, MIX_EVEN);
                // Now and then the sender holds off until the block is empty
                // of work, so results drain with no input pressure.
                if ($urandom_range(0, 199) == 0)
                    wait_drained();
                send_item(pick_opcode(mix), pick_word());
            end
        end

        wait_drained();
        repeat (20)
            @(posedge clk);
        if (mirror.mismatches == 0)
            $display("PASS bounded_double_ended_queue_top");
        else
            $display("FAIL bounded_double_ended_queue_top");
        $finish;
    end

endmodule
